/* rtl/wed_pkg.sv */
// Shared types and constants for the window energy boundary detector.
// Used by wed_lane, wed_merge and window_energy_boundary_detect; no dependencies.
package wed_pkg;

  // Sample and arithmetic widths.
  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int LIMIT_W   = 18;
  localparam int NUM_LANES = 4;

  // Lane order: reference left, test left, reference right, test right.
  localparam int LANE_REF_LEFT   = 0;
  localparam int LANE_TEST_LEFT  = 1;
  localparam int LANE_REF_RIGHT  = 2;
  localparam int LANE_TEST_RIGHT = 3;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_ENERGY_LIMIT = 1'b0;
  localparam logic REG_STEREO_MODE  = 1'b1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(200);

  // Per-beat control shared by the lanes and the merging stage.
  typedef struct packed {
    logic step;   // an input beat is taken this cycle
    logic last;   // that beat closes the frame
    logic evict;  // the window was already full, so the oldest sample leaves
    logic full;   // the window is complete after this beat
  } wed_ctrl_t;

endpackage

/* rtl/wed_lane.sv */
// One sample stream: magnitude, sample history memory, running window sum
// and limit compare. Depends on wed_pkg.
module wed_lane import wed_pkg::*; #(
  parameter int WINDOW_LEN = 5,
  parameter int PTR_W      = 3,
  parameter int SUM_W      = 18
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wed_ctrl_t                  ctrl,
  input  logic [PTR_W-1:0]           wr_addr,
  input  logic [PTR_W-1:0]           rd_addr,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [LIMIT_W-1:0]         limit,
  output logic                       hit
);

  localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

  logic [MAG_W-1:0] hist_mem [WINDOW_LEN];
  logic [MAG_W-1:0] old_mag_r;
  logic [MAG_W-1:0] sample_ext;
  logic [MAG_W-1:0] mag;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;

  // Magnitude of a two's complement sample; the most negative value gives 2^15.
  assign sample_ext = {sample[SAMPLE_W-1], sample};
  assign mag = sample[SAMPLE_W-1] ? (~sample_ext + MAG_W'(1)) : sample_ext;

  // Drop the oldest sample once the window is full, then add the new one.
  assign sum_nxt = sum_r - (ctrl.evict ? SUM_W'(old_mag_r) : SUM_W'(0)) + SUM_W'(mag);

  assign hit = ctrl.step && ctrl.full && (CMP_W'(sum_nxt) > CMP_W'(limit));

  // History memory; the oldest entry for the next beat is fetched ahead of time.
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      hist_mem[wr_addr] <= mag;
    end
    if (ctrl.step && (rd_addr == wr_addr)) begin
      old_mag_r <= mag;
    end else begin
      old_mag_r <= hist_mem[rd_addr];
    end
  end

  // Running sum, cleared at the end of each frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.step) begin
      sum_r <= ctrl.last ? '0 : sum_nxt;
    end
  end

  // A frame close leaves the sum at zero.
  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step && ctrl.last |=> sum_r == '0)
    else $error("window sum not cleared after frame close");

  // Without an eviction the sum cannot shrink.
  a_sum_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step && !ctrl.last && !ctrl.evict |=> sum_r >= $past(sum_r))
    else $error("window sum shrank while the window was filling");

endmodule

/* rtl/wed_merge.sv */
// Merging stage: combines the lane hits into the sticky frame flag and
// queues frame results in a two-entry output buffer. Depends on wed_pkg.
module wed_merge import wed_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wed_ctrl_t            ctrl,
  input  logic [NUM_LANES-1:0] lane_hit,
  input  logic                 stereo,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_boundary_found
);

  logic hit_now;
  logic flag_r;
  logic result;
  logic push;
  logic pop;
  logic head_valid_r;
  logic head_data_r;
  logic skid_valid_r;
  logic skid_data_r;

  // Right-channel lanes count only in stereo mode.
  assign hit_now = lane_hit[LANE_REF_LEFT] || lane_hit[LANE_TEST_LEFT] ||
                   (stereo && (lane_hit[LANE_REF_RIGHT] || lane_hit[LANE_TEST_RIGHT]));
  assign result  = flag_r || hit_now;

  assign push = ctrl.step && ctrl.last;
  assign pop  = head_valid_r && out_ready;

  // Sticky flag for the current frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (ctrl.step) begin
      flag_r <= ctrl.last ? 1'b0 : result;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!head_valid_r) begin
      head_valid_r <= push;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= push;
      end else begin
        head_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid_r || (pop && !skid_valid_r)) begin
      head_data_r <= result;
    end else if (pop) begin
      head_data_r <= skid_data_r;
    end
    if (push) begin
      skid_data_r <= result;
    end
  end

  assign in_ready           = !skid_valid_r;
  assign out_valid          = head_valid_r;
  assign out_boundary_found = head_data_r;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry held while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !pop |-> !push)
    else $error("frame result pushed into a full output buffer");

  a_flag_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !flag_r)
    else $error("frame flag not cleared after frame close");

endmodule

/* rtl/window_energy_boundary_detect.sv */
// Top level of the window energy boundary detector: configuration registers,
// window fill control, four wed_lane instances and wed_merge. Depends on wed_pkg.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------------------
//   in_      | input     | in_valid / in_ready  | ref/test left/right samples, frame_last
//   out_     | output    | out_valid/out_ready  | boundary_found, one beat per frame
//   config   | input     | APB psel/penable     | energy_limit (0x0), stereo_mode (0x4)
//
// One input beat per cycle while in_ready is high; all four streams update in
// parallel lanes, each limited by its running-sum add and limit compare. The
// frame result is registered, in the skid entry if the output is occupied.
// Synchronous active-low reset clears sums, fill count and flag; the history
// memories need no clearing. in_ready drops only when both output entries are full.
module window_energy_boundary_detect import wed_pkg::*; #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_ref_left,
  input  logic signed [SAMPLE_W-1:0] in_test_left,
  input  logic signed [SAMPLE_W-1:0] in_ref_right,
  input  logic signed [SAMPLE_W-1:0] in_test_right,
  input  logic                       in_frame_last,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_boundary_found,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = $clog2(WINDOW_LEN * (1 << SAMPLE_W - 1) + 1);

  logic [LIMIT_W-1:0]         energy_limit_r;
  logic                       stereo_mode_r;
  logic                       cfg_write;
  logic                       reg_sel;
  logic [CNT_W-1:0]           fill_r;
  logic [CNT_W-1:0]           fill_nxt;
  logic [PTR_W-1:0]           pos_r;
  logic [PTR_W-1:0]           pos_nxt;
  logic [PTR_W-1:0]           rd_addr;
  wed_ctrl_t                  ctrl;
  logic [NUM_LANES-1:0]       lane_hit;
  logic signed [SAMPLE_W-1:0] lane_sample [NUM_LANES];

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_limit_r <= LIMIT_RESET;
      stereo_mode_r  <= 1'b0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_ENERGY_LIMIT: energy_limit_r <= pwdata[LIMIT_W-1:0];
        REG_STEREO_MODE:  stereo_mode_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENERGY_LIMIT: prdata = DATA_W'(energy_limit_r);
      REG_STEREO_MODE:  prdata = DATA_W'(stereo_mode_r);
      default:          prdata = '0;
    endcase
  end

  // Window fill control shared by all lanes.
  assign ctrl.step  = in_valid && in_ready;
  assign ctrl.last  = in_frame_last;
  assign ctrl.evict = (fill_r == CNT_W'(WINDOW_LEN));
  assign ctrl.full  = ctrl.evict || (fill_r == CNT_W'(WINDOW_LEN - 1));

  always_comb begin
    if (ctrl.last) begin
      pos_nxt  = '0;
      fill_nxt = '0;
    end else begin
      pos_nxt  = (pos_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : pos_r + PTR_W'(1);
      fill_nxt = ctrl.evict ? fill_r : fill_r + CNT_W'(1);
    end
  end

  // The lanes prefetch the entry that the next beat will evict.
  assign rd_addr = ctrl.step ? pos_nxt : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pos_r  <= '0;
    end else if (ctrl.step) begin
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Four parallel stream lanes.
  assign lane_sample[LANE_REF_LEFT]   = in_ref_left;
  assign lane_sample[LANE_TEST_LEFT]  = in_test_left;
  assign lane_sample[LANE_REF_RIGHT]  = in_ref_right;
  assign lane_sample[LANE_TEST_RIGHT] = in_test_right;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    wed_lane #(
      .WINDOW_LEN (WINDOW_LEN),
      .PTR_W      (PTR_W),
      .SUM_W      (SUM_W)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .wr_addr (pos_r),
      .rd_addr (rd_addr),
      .sample  (lane_sample[g]),
      .limit   (energy_limit_r),
      .hit     (lane_hit[g])
    );
  end

  // Merge lane hits into the frame result.
  wed_merge u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .lane_hit           (lane_hit),
    .stereo             (stereo_mode_r),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_boundary_found (out_boundary_found)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_LEN))
    else $error("fill count beyond window length");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PTR_W'(WINDOW_LEN - 1))
    else $error("write position beyond window length");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step && ctrl.last |=> fill_r == '0 && pos_r == '0)
    else $error("window control not restarted after frame close");

endmodule

/* verif/window_energy_boundary_detect_checker.sv */
`timescale 1ns / 1ps
// Checker for window_energy_boundary_detect: watches the input, result and configuration ports,
// keeps its own sliding-window sums and compares every frame's boundary flag.
// Depends on wed_pkg.
module window_energy_boundary_detect_checker import wed_pkg::*; #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_ref_left,
  input  logic [SAMPLE_W-1:0] in_test_left,
  input  logic [SAMPLE_W-1:0] in_ref_right,
  input  logic [SAMPLE_W-1:0] in_test_right,
  input  logic                in_frame_last,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_boundary_found,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output int                  mismatches,
  output int                  results_owed
);

  localparam int REPORT_LIMIT = 10;

  // Shadow of the configuration registers.
  logic [LIMIT_W-1:0] limit_now;
  logic               stereo_now;

  // Window state of the current frame, one ring per lane with a shared slot.
  logic [MAG_W-1:0]   history [NUM_LANES][WINDOW_LEN];
  logic [LIMIT_W-1:0] lane_sum [NUM_LANES];
  int                 fill;
  int                 slot;
  logic               hit;

  // Boundary flags of closed frames whose result beat has not arrived yet.
  bit                 frame_flags_due [$];

  function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] s);
    return s[SAMPLE_W-1] ? MAG_W'((1 << SAMPLE_W) - s) : MAG_W'(s);
  endfunction

  task automatic clear_frame();
    for (int s = 0; s < NUM_LANES; s++) begin
      lane_sum[s] = '0;
      for (int k = 0; k < WINDOW_LEN; k++) history[s][k] = '0;
    end
    fill = 0;
    slot = 0;
    hit  = 1'b0;
  endtask

  // Advance all four windows by one sample time and close the frame on its last beat.
  task automatic absorb_beat(input logic [SAMPLE_W-1:0] smp [NUM_LANES], input logic last);
    logic [MAG_W-1:0] m;
    for (int s = 0; s < NUM_LANES; s++) begin
      m = sample_mag(smp[s]);
      if (fill == WINDOW_LEN) lane_sum[s] -= LIMIT_W'(history[s][slot]);
      lane_sum[s] += LIMIT_W'(m);
      history[s][slot] = m;
    end
    slot = (slot == WINDOW_LEN - 1) ? 0 : slot + 1;
    if (fill < WINDOW_LEN) fill++;
    // Only complete windows count; the right lanes count only in stereo.
    if (fill == WINDOW_LEN) begin
      if (lane_sum[LANE_REF_LEFT] > limit_now || lane_sum[LANE_TEST_LEFT] > limit_now) begin
        hit = 1'b1;
      end
      if (stereo_now &&
          (lane_sum[LANE_REF_RIGHT] > limit_now || lane_sum[LANE_TEST_RIGHT] > limit_now)) begin
        hit = 1'b1;
      end
    end
    if (last) begin
      frame_flags_due.push_back(hit);
      clear_frame();
    end
  endtask

  task automatic flag_mismatch(input bit pending, input bit want, input logic got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      if (pending) begin
        $display("%0t: boundary_found mismatch, expected %0b, got %0b", $time, want, got);
      end else begin
        $display("%0t: result beat with no frame pending, got %0b", $time, got);
      end
    end
  endtask

  initial mismatches = 0;

  // Everything is sampled at the rising edge, before the block's registers update.
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] smp [NUM_LANES];
    bit                  want;
    if (!rst_n) begin
      clear_frame();
      limit_now  = LIMIT_RESET;
      stereo_now = 1'b0;
      frame_flags_due.delete();
    end else begin
      // Result beats are compared in frame order.
      if (out_valid && out_ready) begin
        if (frame_flags_due.size() == 0) begin
          flag_mismatch(1'b0, 1'b0, out_boundary_found);
        end else begin
          want = frame_flags_due.pop_front();
          if (out_boundary_found !== want) flag_mismatch(1'b1, want, out_boundary_found);
        end
      end
      // Input beats feed the window model.
      if (in_valid && in_ready) begin
        smp[LANE_REF_LEFT]   = in_ref_left;
        smp[LANE_TEST_LEFT]  = in_test_left;
        smp[LANE_REF_RIGHT]  = in_ref_right;
        smp[LANE_TEST_RIGHT] = in_test_right;
        absorb_beat(smp, in_frame_last);
      end
      // Register writes complete in the access cycle.
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_ENERGY_LIMIT: limit_now  = pwdata[LIMIT_W-1:0];
          REG_STEREO_MODE:  stereo_now = pwdata[0];
          default: ;
        endcase
      end
    end
    results_owed = frame_flags_due.size();
  end

endmodule

/* verif/window_energy_boundary_detect_tb.sv */
`timescale 1ns / 1ps
// Testbench top for window_energy_boundary_detect: clock, reset, stimulus and verdict.
// Depends on wed_pkg, the block itself and window_energy_boundary_detect_checker.
module window_energy_boundary_detect_tb;
  import wed_pkg::*;

  localparam int WINDOW_LEN     = 5;
  localparam int MAX_GAP        = 18;
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_BEATS    = 90;
  localparam int NUM_PHASES     = 8;
  localparam int PRESSURE_PHASE = 5;
  localparam int LIMIT_MAX      = 163840;

  localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'({REG_ENERGY_LIMIT, 2'b00});
  localparam logic [ADDR_W-1:0] MODE_ADDR  = ADDR_W'({REG_STEREO_MODE, 2'b00});

  localparam logic [SAMPLE_W-1:0] S_MIN  = 16'h8000;
  localparam logic [SAMPLE_W-1:0] S_MAX  = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] S_ZERO = 16'h0000;
  localparam logic [SAMPLE_W-1:0] S_ONES = 16'hFFFF;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_ref_left;
  logic signed [SAMPLE_W-1:0] in_test_left;
  logic signed [SAMPLE_W-1:0] in_ref_right;
  logic signed [SAMPLE_W-1:0] in_test_right;
  logic                       in_frame_last;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_boundary_found;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  int mismatches;
  int results_owed;
  int quiet_cycles;

  // Knobs shared between the stimulus and the result-side process.
  bit idle_en;
  bit hold_req;

  window_energy_boundary_detect #(.WINDOW_LEN(WINDOW_LEN)) dut (.*);

  window_energy_boundary_detect_checker #(.WINDOW_LEN(WINDOW_LEN)) checker_i (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("window_energy_boundary_detect verification failed");
        $finish;
      end
    end
  end

  // Result side: random stalls while idle_en is set, and one long hold-off on request.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Offer one input beat (after a random gap if idle_en) and hold it until it is taken.
  task automatic send_beat(input logic [SAMPLE_W-1:0] rl, input logic [SAMPLE_W-1:0] tl,
                           input logic [SAMPLE_W-1:0] rr, input logic [SAMPLE_W-1:0] tr,
                           input logic last);
    int gap;
    gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ref_left   <= rl;
    in_test_left  <= tl;
    in_ref_right  <= rr;
    in_test_right <= tr;
    in_frame_last <= last;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed result, then let the pipeline empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly magnitudes scaled to the limit so window sums land on both sides of it.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int lim);
    int kind;
    int mag;
    kind = $urandom_range(0, 7);
    if (kind == 0) return SAMPLE_W'($urandom);
    if (kind == 1) begin
      case ($urandom_range(0, 3))
        0:       return S_MIN;
        1:       return S_MAX;
        2:       return S_ZERO;
        default: return S_ONES;
      endcase
    end
    mag = $urandom_range(0, lim / 3 + 8);
    if (mag > 32768) mag = 32768;
    return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
  endfunction

  // Frames are mostly the window length or a little longer, some short, a few long; tiny ones 1-2.
  function automatic int pick_frame_len(input bit tiny);
    int kind;
    if (tiny) return $urandom_range(1, 2);
    kind = $urandom_range(0, 9);
    if (kind == 0) return $urandom_range(1, WINDOW_LEN - 1);
    if (kind == 1) return $urandom_range(20, 40);
    return $urandom_range(WINDOW_LEN, 12);
  endfunction

  function automatic int phase_limit(input int p);
    case (p)
      0:       return 0;
      1:       return LIMIT_MAX;
      2:       return 200;
      3:       return 1000;
      4:       return $urandom_range(1, LIMIT_MAX);
      5:       return 5000;
      6:       return LIMIT_MAX - 1;
      default: return 30000;
    endcase
  endfunction

  initial begin
    int cur_lim;
    int flen;
    int sent;
    in_valid      = 1'b0;
    in_ref_left   = '0;
    in_test_left  = '0;
    in_ref_right  = '0;
    in_test_right = '0;
    in_frame_last = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    rst_n         = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short frame: full-scale samples but the window never completes.
    for (int i = 0; i < WINDOW_LEN - 1; i++) send_beat(S_MIN, S_MIN, S_MIN, S_MIN, i == 3);
    // A window sum equal to the reset limit is not a boundary.
    for (int i = 0; i < WINDOW_LEN; i++) send_beat(16'd40, S_ZERO, S_ZERO, S_ZERO, i == 4);
    // One more per negative sample on test left goes over it.
    for (int i = 0; i < WINDOW_LEN; i++) begin
      send_beat(S_ZERO, SAMPLE_W'(-41), S_ZERO, S_ZERO, i == 4);
    end
    // Mono mode ignores a loud right channel.
    for (int i = 0; i < WINDOW_LEN; i++) send_beat(S_ZERO, S_ZERO, S_MIN, S_MAX, i == 4);

    // Stereo, limit one below the largest window sum: right channel alone trips it.
    drain_results();
    write_reg(LIMIT_ADDR, DATA_W'(LIMIT_MAX - 1));
    write_reg(MODE_ADDR, DATA_W'(1));
    for (int i = 0; i < WINDOW_LEN; i++) send_beat(S_ZERO, S_ZERO, S_MIN, S_ZERO, i == 4);
    // At the largest limit even all lanes at full scale stay quiet.
    drain_results();
    write_reg(LIMIT_ADDR, DATA_W'(LIMIT_MAX));
    for (int i = 0; i < WINDOW_LEN; i++) send_beat(S_MIN, S_MIN, S_MIN, S_MIN, i == 4);

    // Random phases; a frame left open at a phase end sees the new settings mid-frame.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      cur_lim = phase_limit(p);
      write_reg(LIMIT_ADDR, DATA_W'(cur_lim));
      write_reg(MODE_ADDR, DATA_W'(p % 3 != 1));
      idle_en = !(p == 2 || p == PRESSURE_PHASE);
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        flen = pick_frame_len(p == PRESSURE_PHASE);
        for (int i = 0; i < flen && sent < PHASE_BEATS; i++) begin
          send_beat(pick_sample(cur_lim), pick_sample(cur_lim), pick_sample(cur_lim),
                    pick_sample(cur_lim), i == flen - 1);
          sent++;
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("window_energy_boundary_detect verification clean");
    end else begin
      $display("window_energy_boundary_detect verification failed");
    end
    $finish;
  end

endmodule
